FILE: sv/rlbd_pkg.sv
// shared types, control store and field helpers for the ladder keypad decoder
package rlbd_pkg;

   localparam int NUM_BUTTONS_DEF = 4;
   localparam int PC_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_MARGIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVELS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REPEATS  = 3'd5;

   // step addresses of the control program
   localparam logic [PC_W-1:0] STEP_LOAD = 3'd0;
   localparam logic [PC_W-1:0] STEP_GATE = 3'd1;
   localparam logic [PC_W-1:0] STEP_SCAN = 3'd2;
   localparam logic [PC_W-1:0] STEP_TEST = 3'd3;
   localparam logic [PC_W-1:0] STEP_HIT  = 3'd4;
   localparam logic [PC_W-1:0] STEP_EMIT = 3'd5;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_GATE_CLOSED,
      COND_SCAN_DONE,
      COND_MATCH,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SAMPLE,
      OP_CLEAR,
      OP_EVENT,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_CLICK,
      EV_HOLD,
      EV_REPEAT
   } event_type;

   // op fires only when the jump is not taken
   typedef struct packed {
      cond_type         cond;
      logic [PC_W-1:0]  jump_pc;
      logic [PC_W-1:0]  next_pc;
      op_type           op;
   } uword_type;

   typedef struct packed {
      logic gate_closed;
      logic scan_done;
      logic match;
      logic out_busy;
   } status_type;

   typedef struct packed {
      op_type op;
   } ctl_type;

   typedef struct packed {
      logic [7:0]  margin;
      logic [7:0]  debounce_ms;
      logic [2:0]  button_count;
      logic [39:0] ladder_levels;
      logic [63:0] hold_durations;
      logic [63:0] repeat_intervals;
   } cfg_type;

   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      begin
         case (pc)
            STEP_LOAD: w = '{COND_NO_REQ,      STEP_LOAD, STEP_GATE, OP_LOAD};
            STEP_GATE: w = '{COND_GATE_CLOSED, STEP_EMIT, STEP_SCAN, OP_SAMPLE};
            STEP_SCAN: w = '{COND_SCAN_DONE,   STEP_EMIT, STEP_TEST, OP_NONE};
            STEP_TEST: w = '{COND_MATCH,       STEP_HIT,  STEP_SCAN, OP_CLEAR};
            STEP_HIT:  w = '{COND_NEVER,       STEP_EMIT, STEP_EMIT, OP_EVENT};
            STEP_EMIT: w = '{COND_OUT_BUSY,    STEP_EMIT, STEP_LOAD, OP_EMIT};
            default:   w = '{COND_NEVER,       STEP_LOAD, STEP_LOAD, OP_NONE};
         endcase
         return w;
      end
   endfunction

   function automatic logic [9:0] level_of(input logic [39:0] w, input logic [1:0] i);
      return w[i*10 +: 10];
   endfunction

   function automatic logic [15:0] ms_of(input logic [63:0] w, input logic [1:0] i);
      return w[i*16 +: 16];
   endfunction

endpackage

FILE: sv/rlbd_seq.sv
// control store sequencer: step counter, condition select and conditional jumps
module rlbd_seq
   import rlbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type status,
   output logic       req_tready,
   output ctl_type    ctl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   uword_type       word;
   logic            taken;

   assign word = ucode(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:       taken = 1'b0;
         COND_NO_REQ:      taken = !req_tvalid;
         COND_GATE_CLOSED: taken = status.gate_closed;
         COND_SCAN_DONE:   taken = status.scan_done;
         COND_MATCH:       taken = status.match;
         COND_OUT_BUSY:    taken = status.out_busy;
         default:          taken = 1'b0;
      endcase
   end

   assign pc_in      = taken ? word.jump_pc : word.next_pc;
   assign ctl.op     = taken ? OP_NONE : word.op;
   assign req_tready = (word.cond == COND_NO_REQ);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: sv/rlbd_dp.sv
// datapath: item registers, scan index, button flags, timestamps, result register
module rlbd_dp
   import rlbd_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  cfg_type     cfg,
   input  logic [31:0] req_now_ms,
   input  logic [9:0]  req_reading,
   input  logic        rsp_tready,
   output status_type  status,
   output logic        rsp_valid,
   output logic        rsp_sampled,
   output logic [1:0]  rsp_event_res,
   output logic [1:0]  rsp_button_index
);

   localparam int CNT_W = $clog2(NUM_BUTTONS + 1);

   logic [31:0]            now_ff;
   logic [9:0]             reading_ff;
   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [NUM_BUTTONS-1:0] clicked_ff, clicked_in;
   logic [NUM_BUTTONS-1:0] held_ff, held_in;
   logic [31:0]            last_event_ff, last_event_in;
   logic [31:0]            last_match_ff, last_match_in;
   logic                   sampled_ff, sampled_in;
   event_type              event_ff, event_in;
   logic [1:0]             bidx_ff, bidx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_sampled_ff;
   event_type              rsp_event_ff;
   logic [1:0]             rsp_bidx_ff;

   logic [1:0]  sel;
   logic [2:0]  count_sat;
   logic [9:0]  level;
   logic [10:0] low_side;
   logic [10:0] high_side;
   logic [31:0] since;
   logic        cur_clicked;
   logic        cur_held;

   assign sel       = 2'(scan_idx_ff);
   assign count_sat = (cfg.button_count > 3'(NUM_BUTTONS)) ? 3'(NUM_BUTTONS)
                                                           : cfg.button_count;
   assign level     = level_of(cfg.ladder_levels, sel);
   assign low_side  = {1'b0, reading_ff} + {3'b000, cfg.margin};
   assign high_side = {1'b0, level} + {3'b000, cfg.margin};
   assign since     = now_ff - last_event_ff;

   always_comb begin
      cur_clicked = 1'b0;
      cur_held    = 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (scan_idx_ff == CNT_W'(b)) begin
            cur_clicked = clicked_ff[b];
            cur_held    = held_ff[b];
         end
      end
   end

   assign status.gate_closed = (now_ff - last_match_ff) <= {24'd0, cfg.debounce_ms};
   assign status.scan_done   = 3'(scan_idx_ff) >= count_sat;
   assign status.match       = (low_side >= {1'b0, level}) && ({1'b0, reading_ff} <= high_side);
   assign status.out_busy    = rsp_valid_ff && !rsp_tready;

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      clicked_in    = clicked_ff;
      held_in       = held_ff;
      last_event_in = last_event_ff;
      last_match_in = last_match_ff;
      sampled_in    = sampled_ff;
      event_in      = event_ff;
      bidx_in       = bidx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      case (ctl.op)
         OP_LOAD: begin
            scan_idx_in = '0;
            sampled_in  = 1'b0;
            event_in    = EV_NONE;
            bidx_in     = 2'd0;
         end
         OP_SAMPLE: begin
            sampled_in = 1'b1;
         end
         OP_CLEAR: begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
               if (scan_idx_ff == CNT_W'(b)) begin
                  clicked_in[b] = 1'b0;
                  held_in[b]    = 1'b0;
               end
            end
            scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
         OP_EVENT: begin
            bidx_in       = sel;
            last_match_in = now_ff;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
               if (scan_idx_ff == CNT_W'(b)) begin
                  if (!cur_clicked) begin
                     clicked_in[b] = 1'b1;
                     last_event_in = now_ff;
                     event_in      = EV_CLICK;
                  end else if (cur_held) begin
                     if (since > {16'd0, ms_of(cfg.repeat_intervals, sel)}) begin
                        last_event_in = now_ff;
                        event_in      = EV_REPEAT;
                     end
                  end else if (since > {16'd0, ms_of(cfg.hold_durations, sel)}) begin
                     held_in[b]    = 1'b1;
                     last_event_in = now_ff;
                     event_in      = EV_HOLD;
                  end
               end
            end
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clicked_ff    <= '0;
         held_ff       <= '0;
         last_event_ff <= '0;
         last_match_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clicked_ff    <= clicked_in;
         held_ff       <= held_in;
         last_event_ff <= last_event_in;
         last_match_ff <= last_match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_LOAD) begin
         now_ff     <= req_now_ms;
         reading_ff <= req_reading;
      end
      scan_idx_ff <= scan_idx_in;
      sampled_ff  <= sampled_in;
      event_ff    <= event_in;
      bidx_ff     <= bidx_in;
      if (ctl.op == OP_EMIT) begin
         rsp_sampled_ff <= sampled_ff;
         rsp_event_ff   <= event_ff;
         rsp_bidx_ff    <= bidx_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sampled      = rsp_sampled_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_button_index = rsp_bidx_ff;

`ifndef SYNTHESIS
   a_held_needs_click: assert property (@(posedge clock) disable iff (reset)
      (held_ff & ~clicked_ff) == '0)
      else $error("held flag set on a button that is not clicked");

   a_event_needs_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_event_ff == EV_NONE || rsp_sampled_ff))
      else $error("event reported on an unsampled request");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_CLEAR |-> 3'(scan_idx_ff) < count_sat)
      else $error("scan stepped past the buttons in use");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_EMIT |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten before it was taken");
`endif

endmodule

FILE: sv/resistor_ladder_button_decoder_top.sv
// top level of the resistor ladder keypad decoder: csr bank, sequencer and datapath
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: now_ms[31:0], reading[41:32]
//  rsp      out  rsp_tvalid/rsp_tready  tdata: sampled[0], event_res[2:1], button_index[4:3]
//  csr      in   csr_valid/csr_ready    csr_index, csr_data (register write)
//
// a request runs the steps load, gate and emit when the debounce gate is closed, and else
// load, gate, scan and test for each button in use until one matches, hit on a match, and
// emit; the control program holds a bound check and a compare step per button
// the next request is taken while the previous result still waits in the output register
// reset is synchronous and clears flags, timestamps, registers and the step counter
// csr writes are always accepted
module resistor_ladder_button_decoder_top
   import rlbd_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // now_ms[31:0], reading[41:32], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // sampled[0], event_res[2:1], button_index[4:3]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg_ff;
   status_type status;
   ctl_type    ctl;
   logic       rsp_sampled;
   logic [1:0] rsp_event_res;
   logic [1:0] rsp_button_index;

   // register bank, unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MARGIN:   cfg_ff.margin           <= csr_data[7:0];
            REG_DEBOUNCE: cfg_ff.debounce_ms      <= csr_data[7:0];
            REG_COUNT:    cfg_ff.button_count     <= csr_data[2:0];
            REG_LEVELS:   cfg_ff.ladder_levels    <= csr_data[39:0];
            REG_HOLDS:    cfg_ff.hold_durations   <= csr_data;
            REG_REPEATS:  cfg_ff.repeat_intervals <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // step counter and control store
   rlbd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   // scan, compare and event datapath
   rlbd_dp #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .cfg              (cfg_ff),
      .req_now_ms       (req_tdata[31:0]),
      .req_reading      (req_tdata[41:32]),
      .rsp_tready       (rsp_tready),
      .status           (status),
      .rsp_valid        (rsp_tvalid),
      .rsp_sampled      (rsp_sampled),
      .rsp_event_res    (rsp_event_res),
      .rsp_button_index (rsp_button_index)
   );

   assign rsp_tdata = {3'b000, rsp_button_index, rsp_event_res, rsp_sampled};

endmodule

FILE: dv/resistor_ladder_button_decoder_top_tb.sv
// self-checking testbench for the resistor ladder keypad decoder top level
`timescale 1ns / 100ps

module resistor_ladder_button_decoder_top_tb
   import rlbd_pkg::*;
();

   // register indexes past the end of the map, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT = 4000;
   // cycles allowed after the last response for stray output
   localparam int DRAIN_CYCLES = 40;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // one response word, laid out as rsp_tdata[4:0]
   typedef struct packed {
      logic [1:0] button_index;
      event_type  event_res;
      logic       sampled;
   } keypad_result_type;

   // mirrors the decoder state and keeps the results still owed by the block
   class keypad_event_predictor_type;
      cfg_type           cfg;
      logic [3:0]        clicked;
      logic [3:0]        held;
      logic [31:0]       last_event_ms;
      logic [31:0]       last_match_ms;
      keypad_result_type owed[$];
      int                failures;

      function new();
         cfg = '0;
         clicked = '0;
         held = '0;
         last_event_ms = '0;
         last_match_ms = '0;
         failures = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
         case (idx)
            REG_MARGIN:   cfg.margin = data[7:0];
            REG_DEBOUNCE: cfg.debounce_ms = data[7:0];
            REG_COUNT:    cfg.button_count = data[2:0];
            REG_LEVELS:   cfg.ladder_levels = data[39:0];
            REG_HOLDS:    cfg.hold_durations = data;
            REG_REPEATS:  cfg.repeat_intervals = data;
            default: ;
         endcase
      endfunction

      function void note_sample(input logic [31:0] now, input logic [9:0] reading);
         keypad_result_type r;
         logic [31:0]       since_match;
         logic [31:0]       since_event;
         logic [15:0]       hold_ms;
         logic [15:0]       repeat_ms;
         int                in_use;
         int                lvl;
         int                lo;
         int                hi;
         int                rd;
         r.sampled = 1'b0;
         r.event_res = EV_NONE;
         r.button_index = 2'd0;
         since_match = now - last_match_ms;
         if (since_match > {24'd0, cfg.debounce_ms}) begin
            r.sampled = 1'b1;
            in_use = (cfg.button_count > NUM_BUTTONS_DEF) ? NUM_BUTTONS_DEF : cfg.button_count;
            rd = reading;
            for (int i = 0; i < in_use; i++) begin
               lvl = cfg.ladder_levels[i*10 +: 10];
               lo = lvl - int'(cfg.margin);
               hi = lvl + int'(cfg.margin);
               if (rd >= lo && rd <= hi) begin
                  since_event = now - last_event_ms;
                  hold_ms = cfg.hold_durations[i*16 +: 16];
                  repeat_ms = cfg.repeat_intervals[i*16 +: 16];
                  r.button_index = i[1:0];
                  if (!clicked[i]) begin
                     clicked[i] = 1'b1;
                     last_event_ms = now;
                     r.event_res = EV_CLICK;
                  end else if (held[i]) begin
                     if (since_event > {16'd0, repeat_ms}) begin
                        last_event_ms = now;
                        r.event_res = EV_REPEAT;
                     end
                  end else if (since_event > {16'd0, hold_ms}) begin
                     held[i] = 1'b1;
                     last_event_ms = now;
                     r.event_res = EV_HOLD;
                  end
                  last_match_ms = now;
                  break;
               end
               // scanned past without a match
               clicked[i] = 1'b0;
               held[i] = 1'b0;
            end
         end
         owed.push_back(r);
      endfunction

      function void check_result(input logic [7:0] tdata);
         keypad_result_type want;
         keypad_result_type got;
         got = keypad_result_type'(tdata[4:0]);
         if (owed.size() == 0) begin
            $display("%0t: response %h with nothing outstanding", $time, tdata);
            failures++;
            return;
         end
         want = owed.pop_front();
         if (got.sampled !== want.sampled) begin
            $display("%0t: sampled expected %0d actual %0d", $time, want.sampled, got.sampled);
            failures++;
         end
         if (got.event_res !== want.event_res) begin
            $display("%0t: event_res expected %0d actual %0d",
                     $time, want.event_res, got.event_res);
            failures++;
         end
         if (got.button_index !== want.button_index) begin
            $display("%0t: button_index expected %0d actual %0d",
                     $time, want.button_index, got.button_index);
            failures++;
         end
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;    // now_ms[31:0], reading[41:32], zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // sampled[0], event_res[2:1], button_index[4:3]
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   keypad_event_predictor_type keypad = new();

   // idling knobs, percent of cycles
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;

   // press pattern state for the random stimulus
   int          press_button = 0;
   int          press_left = 0;
   logic [31:0] now_ms = '0;

   resistor_ladder_button_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver side: back pressure decided once per cycle at the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
   end

   // every accepted response goes straight to the checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         keypad.check_result(rsp_tdata);
      end
   end

   // hang detection: cycles in which no channel moves anything
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("resistor_ladder_button_decoder_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void set_idling(input idle_mode_type mode);
      tx_idle_pct = (mode == IDLE_SENDER) ? 82 : (mode == IDLE_BOTH) ? 20 : 0;
      rx_stall_pct = (mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 20 : 0;
   endfunction

   // valid stays up across back-to-back writes, csr_release drops it
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      keypad.write_reg(idx, data);
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one request, with an optional sender gap in front of it
   task automatic send_request(input logic [31:0] now, input logic [9:0] reading);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, reading, now};
      do @(posedge clock); while (!req_tready);
      keypad.note_sample(now, reading);
   endtask

   task automatic request_release();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (keypad.pending() != 0) @(posedge clock);
   endtask

   // random bits above the register width, the block must mask them off
   function automatic logic [63:0] junk_above(input logic [63:0] v, input int w);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return (r & ~((64'd1 << w) - 64'd1)) | v;
   endfunction

   function automatic logic [63:0] short_delays(input int top);
      logic [63:0] r;
      for (int i = 0; i < 4; i++) r[i*16 +: 16] = $urandom_range(0, top);
      return r;
   endfunction

   function automatic logic [39:0] any_levels();
      logic [39:0] r;
      for (int i = 0; i < 4; i++) r[i*10 +: 10] = $urandom_range(0, 1023);
      return r;
   endfunction

   // register set for each random phase, extremes spread over the phases
   task automatic apply_settings(input int phase);
      logic [7:0]  m;
      logic [7:0]  d;
      logic [2:0]  cnt;
      logic [39:0] lv;
      logic [63:0] hd;
      logic [63:0] rp;
      m = $urandom_range(1, 40);
      d = $urandom_range(0, 20);
      cnt = $urandom_range(1, 4);
      lv = any_levels();
      hd = short_delays(60);
      rp = short_delays(30);
      case (phase)
         0: cnt = 3'd4;
         1: begin
            // tightest match window, levels at both ends of the adc range
            m = 8'd0;
            d = 8'd0;
            cnt = 3'd4;
            lv[9:0] = 10'd0;
            lv[39:30] = 10'd1023;
         end
         2: begin
            // widest window and longest debounce, count saturates
            m = 8'd255;
            d = 8'd255;
            cnt = 3'd7;
         end
         4: begin
            cnt = 3'd4;
            hd = {$urandom, $urandom};
            rp = {$urandom, $urandom};
         end
         5: cnt = 3'd0;
         6: begin
            // zero delays: every repeated match is due
            cnt = 3'd4;
            hd = '0;
            rp = '0;
         end
         7: begin
            cnt = 3'd5;
            hd = '1;
            rp = '1;
         end
         default: ;
      endcase
      write_csr(REG_MARGIN, junk_above(m, 8));
      write_csr(REG_DEBOUNCE, junk_above(d, 8));
      write_csr(REG_COUNT, junk_above(cnt, 3));
      write_csr(REG_LEVELS, junk_above(lv, 40));
      write_csr(REG_HOLDS, hd);
      write_csr(REG_REPEATS, rp);
      csr_release();
   endtask

   // mostly presses of one button held for a while, some noise in between
   function automatic logic [9:0] next_reading();
      int lvl;
      int span;
      int off;
      int v;
      if (press_left == 0) begin
         if ($urandom_range(99) < 80) begin
            press_button = $urandom_range(0, 3);
            press_left = $urandom_range(1, 12);
         end else begin
            press_button = -1;
            press_left = $urandom_range(1, 3);
         end
      end
      press_left--;
      if (press_button < 0) return 10'($urandom_range(0, 1023));
      lvl = keypad.cfg.ladder_levels[press_button*10 +: 10];
      span = keypad.cfg.margin + 2;
      off = $urandom_range(0, 2 * span);
      v = lvl + off - span;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[9:0];
   endfunction

   // time steps scaled to the debounce setting, with the odd long jump and wrap
   function automatic logic [31:0] next_step();
      int p;
      p = $urandom_range(99);
      if (p < 70) return $urandom_range(0, 2 * keypad.cfg.debounce_ms + 30);
      if (p < 95) return $urandom_range(0, 400);
      return $urandom;
   endfunction

   initial begin
      int n_items;
      set_idling(IDLE_NONE);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part: levels at 0, 1023, 512, 300 with a margin of 2
      write_csr(REG_MARGIN, 64'd2);
      write_csr(REG_DEBOUNCE, 64'd0);
      write_csr(REG_COUNT, 64'd4);
      write_csr(REG_LEVELS, {24'd0, 10'd300, 10'd512, 10'd1023, 10'd0});
      write_csr(REG_HOLDS, {16'd5, 16'd5, 16'd5, 16'd5});
      write_csr(REG_REPEATS, {16'd3, 16'd3, 16'd3, 16'd3});
      // unmapped indexes, nothing may change
      write_csr(REG_SPARE_LO, '1);
      write_csr(REG_SPARE_HI, {$urandom, $urandom});
      csr_release();

      send_request(32'd0, 10'd0);              // gate closed right after reset
      send_request(32'd1, 10'd0);              // click on button 0
      send_request(32'd2, 10'd1);              // match, hold not yet due
      send_request(32'd10, 10'd2);             // hold start
      send_request(32'd12, 10'd0);             // held, repeat not yet due
      send_request(32'd20, 10'd0);             // hold repeat
      send_request(32'd21, 10'd1023);          // button 0 cleared, click on button 1
      send_request(32'd22, 10'd1021);          // match without a due event
      send_request(32'd30, 10'd700);           // no match clears everything
      send_request(32'd31, 10'd514);           // click on button 2
      send_request(32'd32, 10'd298);           // click on button 3
      send_request(32'd33, 10'd1022);          // button 1 again from scratch
      send_request(32'd40, 10'd1023);          // hold start on button 1
      send_request(32'hFFFF_FFF0, 10'd1023);   // far future, repeat
      send_request(32'h0000_0005, 10'd1023);   // wrapped time difference, repeat
      send_request(32'h0000_0005, 10'd1023);   // zero gap, gate closed
      send_request(32'd6, 10'd0);              // click on button 0
      send_request(32'd7, 10'd1);              // nothing due
      send_request(32'd100, 10'd1023);         // repeat on button 1
      send_request(32'd101, 10'd300);          // button 3 again
      request_release();
      wait_drained();
      now_ms = 32'd101;

      for (int phase = 0; phase < 8; phase++) begin
         apply_settings(phase);
         set_idling(idle_mode_type'(phase % 4));
         n_items = (phase == 5) ? 60 : 250;
         for (int k = 0; k < n_items; k++) begin
            now_ms = now_ms + next_step();
            send_request(now_ms, next_reading());
         end
         request_release();
         wait_drained();
      end

      // let any stray response show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (keypad.failures == 0 && keypad.pending() == 0) begin
         $display("resistor_ladder_button_decoder_top: match");
      end else begin
         $display("resistor_ladder_button_decoder_top: mismatch");
      end
      $finish;
   end

endmodule
